// ----- sv/kwm_pkg.sv -----
// kwm_pkg: shared field widths, the ways_in_use reset constant and the queue entry type
// for the k-way sorted pair merge unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    // fixed field widths
    localparam int WAY_W = 4;
    localparam int KEY_W = 31;
    localparam int CFG_W = 4;

    // ways_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // one classified input beat as it waits between front and back
    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic [KEY_W-1:0] tid;
        logic [KEY_W-1:0] docid;
        logic             done;
        logic             in_range;
    } kwm_entry_t;

endpackage

`default_nettype wire

// ----- sv/kwm_front.sv -----
// kwm_front: input side of the merge unit; takes beats and tags them with
// an active-way range check before they enter the queue.
// Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_front #(
    parameter int CNT_W = 4
) (
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [kwm_pkg::WAY_W-1:0] way,
    input  wire logic [kwm_pkg::KEY_W-1:0] tid,
    input  wire logic [kwm_pkg::KEY_W-1:0] docid,
    input  wire logic                      way_done,
    input  wire logic [CNT_W-1:0]          active_n,
    input  wire logic                      q_full,
    output logic                           q_push,
    output kwm_pkg::kwm_entry_t            q_entry
);
    import kwm_pkg::*;

    localparam int CMP_W = WAY_W + 1;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // classify: way must sit below the active way count
    always_comb
    begin
        q_entry.way      = way;
        q_entry.tid      = tid;
        q_entry.docid    = docid;
        q_entry.done     = way_done;
        q_entry.in_range = ({1'b0, way} < CMP_W'(active_n));
    end

endmodule

`default_nettype wire

// ----- sv/kwm_fifo.sv -----
// kwm_fifo: two-entry queue that decouples the front from the back of the
// merge unit.
// Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire kwm_pkg::kwm_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output kwm_pkg::kwm_entry_t      pop_data
);
    import kwm_pkg::*;

    kwm_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/kwm_back.sv -----
// kwm_back: head registers, minimum-search tree and output register of the
// merge unit; applies one queued beat per cycle unless the output stalls.
// Emits once every active way holds a head or has ended. Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_back #(
    parameter int WAYS  = 10,
    parameter int CNT_W = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [CNT_W-1:0]          active_n,
    input  wire logic                      q_empty,
    input  wire kwm_pkg::kwm_entry_t       q_entry,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [kwm_pkg::KEY_W-1:0]      out_tid,
    output logic [kwm_pkg::KEY_W-1:0]      out_docid,
    output logic [kwm_pkg::WAY_W-1:0]      source_way,
    output logic                           merge_done
);
    import kwm_pkg::*;

    localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LEAVES = 1 << IDX_W;

    typedef struct packed {
        logic               vld;
        logic [2*KEY_W-1:0] key;
        logic [IDX_W-1:0]   idx;
    } node_t;

    logic [KEY_W-1:0] head_term_reg [WAYS];
    logic [KEY_W-1:0] head_doc_reg  [WAYS];
    logic [KEY_W-1:0] head_term_next[WAYS];
    logic [KEY_W-1:0] head_doc_next [WAYS];
    logic [WAYS-1:0]  head_valid_reg, head_valid_next, valid_upd;
    logic [WAYS-1:0]  way_ended_reg, way_ended_next, ended_upd;
    logic [WAYS-1:0]  active_mask, load_sel;

    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] out_tid_reg, out_tid_next;
    logic [KEY_W-1:0] out_docid_reg, out_docid_next;
    logic [WAY_W-1:0] source_way_reg, source_way_next;
    logic             merge_done_reg, merge_done_next;

    node_t node[1:2*LEAVES-1];

    logic all_ready;
    logic emit;
    logic emit_pair;
    logic emit_end;

    // take a beat when the output register is free or draining
    assign q_pop = !q_empty && (!out_valid_reg || out_ready);

    // per-way decode of the beat against the current head state
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            active_mask[i] = (CNT_W'(i) < active_n);
            load_sel[i]    = q_pop && q_entry.in_range && (q_entry.way == WAY_W'(i))
                             && !head_valid_reg[i] && !way_ended_reg[i];
            valid_upd[i]   = head_valid_reg[i] | (load_sel[i] & !q_entry.done);
            ended_upd[i]   = way_ended_reg[i] | (load_sel[i] & q_entry.done);
            head_term_next[i] = (load_sel[i] && !q_entry.done) ? q_entry.tid
                                                               : head_term_reg[i];
            head_doc_next[i]  = (load_sel[i] && !q_entry.done) ? q_entry.docid
                                                               : head_doc_reg[i];
        end
    end

    // every active way holds a head or has ended
    assign all_ready = &(valid_upd | ended_upd | ~active_mask);

    // leaves of the minimum tree, padded with empty nodes
    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < WAYS)
            begin : g_real
                assign node[LEAVES+g].vld = valid_upd[g] && active_mask[g];
                assign node[LEAVES+g].key = {head_term_next[g], head_doc_next[g]};
                assign node[LEAVES+g].idx = IDX_W'(g);
            end
            else
            begin : g_pad
                assign node[LEAVES+g].vld = 1'b0;
                assign node[LEAVES+g].key = '0;
                assign node[LEAVES+g].idx = IDX_W'(g);
            end
        end

        // inner nodes: lower way wins on equal keys
        for (g = LEAVES - 1; g >= 1; g--)
        begin : g_node
            logic take_left;
            assign take_left = node[2*g].vld &&
                               (!node[2*g+1].vld || (node[2*g].key <= node[2*g+1].key));
            assign node[g] = take_left ? node[2*g] : node[2*g+1];
        end
    endgenerate

    assign emit      = q_pop && all_ready;
    assign emit_pair = emit && node[1].vld;
    assign emit_end  = emit && !node[1].vld;

    // head state after the beat and any emission
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            head_valid_next[i] = valid_upd[i] && !emit_end &&
                                 !(emit_pair && (node[1].idx == IDX_W'(i)));
            way_ended_next[i]  = ended_upd[i] && !emit_end;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_tid_next    = out_tid_reg;
        out_docid_next  = out_docid_reg;
        source_way_next = source_way_reg;
        merge_done_next = merge_done_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_tid_next    = emit_pair ? node[1].key[2*KEY_W-1:KEY_W] : '0;
            out_docid_next  = emit_pair ? node[1].key[KEY_W-1:0] : '0;
            source_way_next = emit_pair ? WAY_W'(node[1].idx) : '0;
            merge_done_next = emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            way_ended_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            way_ended_reg  <= way_ended_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            head_term_reg[i] <= head_term_next[i];
            head_doc_reg[i]  <= head_doc_next[i];
        end
        out_tid_reg    <= out_tid_next;
        out_docid_reg  <= out_docid_next;
        source_way_reg <= source_way_next;
        merge_done_reg <= merge_done_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_tid    = out_tid_reg;
    assign out_docid  = out_docid_reg;
    assign source_way = source_way_reg;
    assign merge_done = merge_done_reg;

endmodule

`default_nettype wire

// ----- sv/kway_sorted_pair_merge_unit.sv -----
// K-way merge of sorted (term id, document id) streams. Each input beat either
// loads the next pair of one way or ends that way; once every active way
// holds a head or has ended, the smallest head (ties to the lowest way) comes
// out with its way number so the host knows which way to refill, and when all
// active ways have ended an end marker comes out and the unit clears its heads.
// Rate: one beat per cycle sustained while out_ready stays high; an accepted
// beat is written into the queue, and once popped it goes through the head
// update and compare tree into the output register. The cycle time is set by
// the ceil(log2(WAYS))-level compare tree over 62-bit keys in the back end.
// The user must write ways_in_use only while idle; the unit does not enforce
// it.
// Depends on kwm_pkg, kwm_front, kwm_fifo and kwm_back.
`timescale 1ns / 1ps
`default_nettype none

module kway_sorted_pair_merge_unit #(
    parameter int WAYS = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [kwm_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [kwm_pkg::WAY_W-1:0] way,
    input  wire logic [kwm_pkg::KEY_W-1:0] tid,
    input  wire logic [kwm_pkg::KEY_W-1:0] docid,
    input  wire logic                      way_done,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [kwm_pkg::KEY_W-1:0]      out_tid,
    output logic [kwm_pkg::KEY_W-1:0]      out_docid,
    output logic [kwm_pkg::WAY_W-1:0]      source_way,
    output logic                           merge_done
);
    import kwm_pkg::*;

    localparam int CNT_W = $clog2(WAYS + 1);
    localparam logic [CFG_W:0] WAYS_LIM = (CFG_W + 1)'(WAYS);

    logic [CFG_W-1:0] ways_in_use_reg, ways_in_use_next;
    logic [CNT_W-1:0] active_n;

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    kwm_entry_t q_in;
    kwm_entry_t q_out;

    // configuration register
    assign ways_in_use_next = cfg_wr_en ? cfg_wr_data : ways_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_in_use_reg <= CFG_RESET;
        end
        else
        begin
            ways_in_use_reg <= ways_in_use_next;
        end
    end

    // active way count, clamped to 1..WAYS
    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if ({1'b0, ways_in_use_reg} > WAYS_LIM)
        begin
            active_n = CNT_W'(WAYS);
        end
        else
        begin
            active_n = CNT_W'(ways_in_use_reg);
        end
    end

    kwm_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .way      (way),
        .tid      (tid),
        .docid    (docid),
        .way_done (way_done),
        .active_n (active_n),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    kwm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    kwm_back #(
        .WAYS  (WAYS),
        .CNT_W (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .active_n   (active_n),
        .q_empty    (q_empty),
        .q_entry    (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_tid    (out_tid),
        .out_docid  (out_docid),
        .source_way (source_way),
        .merge_done (merge_done)
    );

endmodule

`default_nettype wire

// ----- sv/kwm_checker.sv -----
// kwm_checker: port-level assertions for the merge unit, attached to the
// top level by the bind at the end of this file.
// Depends on kwm_pkg and kway_sorted_pair_merge_unit.
`timescale 1ns / 1ps
`default_nettype none

module kwm_checker #(
    parameter int WAYS = 10
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [kwm_pkg::KEY_W-1:0] out_tid,
    input wire logic [kwm_pkg::KEY_W-1:0] out_docid,
    input wire logic [kwm_pkg::WAY_W-1:0] source_way,
    input wire logic                      merge_done
);
    import kwm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_tid) &&
        $stable(out_docid) && $stable(source_way) && $stable(merge_done))
        else $error("result beat changed while stalled");

    // end marker carries zero pair fields
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merge_done |-> out_tid == '0 && out_docid == '0 &&
        source_way == '0)
        else $error("end marker with nonzero pair fields");

    // a pair result names an existing way
    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !merge_done |-> {1'b0, source_way} < (WAY_W + 1)'(WAYS))
        else $error("source way out of range");

    // the queue has room right after reset
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind kway_sorted_pair_merge_unit kwm_checker #(.WAYS(WAYS)) u_kwm_checker (.*);

`default_nettype wire
